[src/mgps_pkg.sv]
// Shared constants for the magnitude-gated phase substitution core.
// Field widths, CORDIC angle table and gain correction. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mgps_pkg;

   // word field widths
   localparam int COMPONENT_WIDTH_DEFAULT = 16;
   localparam int PHASE_WIDTH             = 16;
   localparam int THRESH_WIDTH            = 16;
   localparam int OUT_WIDTH               = 17;

   // CORDIC arithmetic
   localparam int CORDIC_STAGES = 24;
   localparam int ANGLE_WIDTH   = 32;   // binary angle, 2^32 per full turn
   localparam int FRAC_BITS     = 16;   // fraction bits of x and y
   localparam int KINV_WIDTH    = 30;
   localparam int KINV_SHIFT    = 14;
   localparam int GROWTH_BITS   = 19;   // x/y width over the component width

   // 1/K scaled by 2^30
   localparam logic [KINV_WIDTH-1:0] KINV = 30'd652032874;

   // quadrant folding limits on the 16-bit angle, held in 17 bits
   localparam logic signed [PHASE_WIDTH:0] QUARTER_TURN = 17'sd16384;
   localparam logic signed [PHASE_WIDTH:0] HALF_TURN    = 17'sd32768;

   // rounded arctangent of 2^-i, 2^32 per full turn
   localparam logic signed [ANGLE_WIDTH-1:0] ATAN_STEPS [CORDIC_STAGES] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81
   };

endpackage
`default_nettype wire

[src/mgps_if.sv]
// Handshake channels of the magnitude-gated phase substitution core:
// sample words in, result words out, threshold writes. Uses mgps_pkg.
`timescale 1ns / 1ps
`default_nettype none

// sample word channel
interface mgps_req_if #(
   parameter int COMPONENT_WIDTH = mgps_pkg::COMPONENT_WIDTH_DEFAULT
);
   logic                                 valid;
   logic                                 ready;
   logic signed [COMPONENT_WIDTH-1:0]    sample_re;
   logic signed [COMPONENT_WIDTH-1:0]    sample_im;
   logic signed [mgps_pkg::PHASE_WIDTH-1:0] new_phase;

   modport source (output valid, sample_re, sample_im, new_phase, input ready);
   modport sink   (input valid, sample_re, sample_im, new_phase, output ready);
endinterface

// result word channel
interface mgps_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mgps_pkg::OUT_WIDTH-1:0] out_re;
   logic signed [mgps_pkg::OUT_WIDTH-1:0] out_im;
   logic                                  phase_zeroed;

   modport source (output valid, out_re, out_im, phase_zeroed, input ready);
   modport sink   (input valid, out_re, out_im, phase_zeroed, output ready);
endinterface

// threshold register write channel
interface mgps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mgps_pkg::THRESH_WIDTH-1:0]   mag_threshold;

   modport source (output valid, mag_threshold, input ready);
   modport sink   (input valid, mag_threshold, output ready);
endinterface

`default_nettype wire

[src/magnitude_gated_phase_substitution_core.sv]
// Top level: magnitude by a square root cell chain, threshold gate, and
// substitution of the phase through a CORDIC cell chain.
// Uses mgps_pkg, mgps_if, mgps_sqrt_cell and mgps_cordic_cell.
//
//   channel   direction   handshake        payload
//   req_bus   in          valid / ready    sample_re, sample_im, new_phase
//   rsp_bus   out         valid / ready    out_re, out_im, phase_zeroed
//   csr_bus   in          valid / ready    mag_threshold (always ready)
//
// One word per clock. The stages in order: input, square and sum stages, one
// root cell per magnitude bit, a scale stage, 24 CORDIC cells and the output
// register. The whole chain advances whenever the output register is empty or
// being taken; a stalled output holds every stage.
// Synchronous reset clears all valid bits and sets the threshold to zero.
`timescale 1ns / 1ps
`default_nettype none
module magnitude_gated_phase_substitution_core #(
   parameter int COMPONENT_WIDTH = mgps_pkg::COMPONENT_WIDTH_DEFAULT
) (
   input  wire      clock,
   input  wire      reset,
   mgps_req_if.sink   req_bus,
   mgps_rsp_if.source rsp_bus,
   mgps_csr_if.sink   csr_bus
);
   localparam int CW    = COMPONENT_WIDTH;
   localparam int PW    = mgps_pkg::PHASE_WIDTH;
   localparam int OW    = mgps_pkg::OUT_WIDTH;
   localparam int AW    = mgps_pkg::ANGLE_WIDTH;
   localparam int FB    = mgps_pkg::FRAC_BITS;
   localparam int KW    = mgps_pkg::KINV_WIDTH;
   localparam int NST   = mgps_pkg::CORDIC_STAGES;
   localparam int SW    = 2 * CW;                  // radicand width
   localparam int MW    = CW;                      // magnitude width
   localparam int NB    = CW;                      // root cells
   localparam int TW    = (MW > mgps_pkg::THRESH_WIDTH) ? MW : mgps_pkg::THRESH_WIDTH;
   localparam int XW0   = CW + mgps_pkg::GROWTH_BITS;
   localparam int XW    = (XW0 > FB + OW + 1) ? XW0 : FB + OW + 1;
   localparam int PRW   = MW + KW;
   localparam int SQ_SIDE = PW + 1;                // {zero phase, angle}
   localparam int CO_SIDE = MW + 1;                // {gate, magnitude}
   localparam logic signed [XW-1:0] ROUND_HALF = XW'(1) << (FB - 1);

   // chain advance: output empty or taken
   logic rsp_valid_ff;
   logic adv;
   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // threshold register
   logic [mgps_pkg::THRESH_WIDTH-1:0] thresh_ff;
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (csr_bus.valid) begin
         thresh_ff <= csr_bus.mag_threshold;
      end
   end

   // input register
   logic                 in_valid_ff;
   logic signed [CW-1:0] re_ff, im_ff;
   logic signed [PW-1:0] ang_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_bus.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         re_ff  <= req_bus.sample_re;
         im_ff  <= req_bus.sample_im;
         ang_ff <= req_bus.new_phase;
      end
   end

   // absolute values and squares
   logic [CW-1:0]      abs_re, abs_im;
   logic               zero_phase;
   logic               sq_valid_ff;
   logic [SW-1:0]      sq_re_ff, sq_im_ff;
   logic [SQ_SIDE-1:0] sq_side_ff;
   always_comb begin
      abs_re     = re_ff[CW-1] ? (~re_ff + CW'(1)) : re_ff;
      abs_im     = im_ff[CW-1] ? (~im_ff + CW'(1)) : im_ff;
      zero_phase = (im_ff == '0) && !re_ff[CW-1];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff <= in_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_re_ff   <= SW'(abs_re) * SW'(abs_re);
         sq_im_ff   <= SW'(abs_im) * SW'(abs_im);
         sq_side_ff <= {zero_phase, ang_ff};
      end
   end

   // sum of squares
   logic               sum_valid_ff;
   logic [SW-1:0]      sum_ff;
   logic [SQ_SIDE-1:0] sum_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         sum_valid_ff <= sq_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff      <= sq_re_ff + sq_im_ff;
         sum_side_ff <= sq_side_ff;
      end
   end

   // square root chain, one cell per root bit
   logic               rt_valid [NB+1];
   logic [SW-1:0]      rt_rad   [NB+1];
   logic [SW:0]        rt_res   [NB+1];
   logic [SQ_SIDE-1:0] rt_side  [NB+1];
   assign rt_valid[0] = sum_valid_ff;
   assign rt_rad[0]   = sum_ff;
   assign rt_res[0]   = '0;
   assign rt_side[0]  = sum_side_ff;

   for (genvar k = 0; k < NB; k++) begin : g_root
      mgps_sqrt_cell #(
         .RAD_WIDTH  (SW),
         .BIT_POS    (2 * (NB - 1 - k)),
         .SIDE_WIDTH (SQ_SIDE)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .valid_i (rt_valid[k]),
         .rad_i   (rt_rad[k]),
         .res_i   (rt_res[k]),
         .side_i  (rt_side[k]),
         .valid_o (rt_valid[k+1]),
         .rad_o   (rt_rad[k+1]),
         .res_o   (rt_res[k+1]),
         .side_o  (rt_side[k+1])
      );
   end

   // gate decision, gain-corrected start vector, quadrant fold
   logic [MW-1:0]         mag;
   logic                  rt_zero_phase;
   logic signed [PW:0]    ang_wide, ang_fold;
   logic                  fold;
   logic                  gate;
   logic [PRW-1:0]        prod;
   logic [XW-1:0]         x_abs;
   logic                  sc_valid_ff;
   logic signed [XW-1:0]  x0_ff;
   logic signed [AW-1:0]  z0_ff;
   logic [CO_SIDE-1:0]    sc_side_ff;
   always_comb begin
      mag           = rt_res[NB][MW-1:0];
      rt_zero_phase = rt_side[NB][PW];
      ang_wide      = {rt_side[NB][PW-1], rt_side[NB][PW-1:0]};
      gate          = (TW'(mag) < TW'(thresh_ff)) || rt_zero_phase;
      unique if (ang_wide > mgps_pkg::QUARTER_TURN) begin
         fold     = 1'b1;
         ang_fold = ang_wide - mgps_pkg::HALF_TURN;
      end else if (ang_wide < -mgps_pkg::QUARTER_TURN) begin
         fold     = 1'b1;
         ang_fold = ang_wide + mgps_pkg::HALF_TURN;
      end else begin
         fold     = 1'b0;
         ang_fold = ang_wide;
      end
      prod  = PRW'(mag) * PRW'(mgps_pkg::KINV);
      x_abs = XW'(prod[PRW-1:mgps_pkg::KINV_SHIFT]);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else if (adv) begin
         sc_valid_ff <= rt_valid[NB];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff      <= fold ? -x_abs : x_abs;
         z0_ff      <= {ang_fold[PW-1:0], (AW - PW)'(0)};
         sc_side_ff <= {gate, mag};
      end
   end

   // CORDIC chain
   logic                 co_valid [NST+1];
   logic signed [XW-1:0] co_x     [NST+1];
   logic signed [XW-1:0] co_y     [NST+1];
   logic signed [AW-1:0] co_z     [NST+1];
   logic [CO_SIDE-1:0]   co_side  [NST+1];
   assign co_valid[0] = sc_valid_ff;
   assign co_x[0]     = x0_ff;
   assign co_y[0]     = '0;
   assign co_z[0]     = z0_ff;
   assign co_side[0]  = sc_side_ff;

   for (genvar i = 0; i < NST; i++) begin : g_rot
      mgps_cordic_cell #(
         .XY_WIDTH   (XW),
         .SHIFT      (i),
         .SIDE_WIDTH (CO_SIDE)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .valid_i (co_valid[i]),
         .x_i     (co_x[i]),
         .y_i     (co_y[i]),
         .z_i     (co_z[i]),
         .side_i  (co_side[i]),
         .valid_o (co_valid[i+1]),
         .x_o     (co_x[i+1]),
         .y_o     (co_y[i+1]),
         .z_o     (co_z[i+1]),
         .side_o  (co_side[i+1])
      );
   end

   // rounding and output selection
   logic signed [XW-1:0] x_rnd, y_rnd;
   logic                 out_gate;
   logic [MW-1:0]        out_mag;
   logic signed [OW-1:0] out_re_ff, out_im_ff;
   logic                 zeroed_ff;
   always_comb begin
      x_rnd    = co_x[NST] + ROUND_HALF;
      y_rnd    = co_y[NST] + ROUND_HALF;
      out_gate = co_side[NST][MW];
      out_mag  = co_side[NST][MW-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= co_valid[NST];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         if (out_gate) begin
            out_re_ff <= OW'(out_mag);
            out_im_ff <= '0;
         end else begin
            out_re_ff <= x_rnd[FB+OW-1:FB];
            out_im_ff <= y_rnd[FB+OW-1:FB];
         end
         zeroed_ff <= out_gate;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_re       = out_re_ff;
   assign rsp_bus.out_im       = out_im_ff;
   assign rsp_bus.phase_zeroed = zeroed_ff;
endmodule
`default_nettype wire

[src/mgps_sqrt_cell.sv]
// One cell of the integer square root chain: settles one root bit.
// Carries side data along with the remainder. Stand-alone, no package use.
`timescale 1ns / 1ps
`default_nettype none
module mgps_sqrt_cell #(
   parameter int RAD_WIDTH  = 32,
   parameter int BIT_POS    = 30,
   parameter int SIDE_WIDTH = 17
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     valid_i,
   input  wire  [RAD_WIDTH-1:0]    rad_i,
   input  wire  [RAD_WIDTH:0]      res_i,
   input  wire  [SIDE_WIDTH-1:0]   side_i,
   output logic                    valid_o,
   output logic [RAD_WIDTH-1:0]    rad_o,
   output logic [RAD_WIDTH:0]      res_o,
   output logic [SIDE_WIDTH-1:0]   side_o
);
   localparam logic [RAD_WIDTH:0] BIT_VAL = (RAD_WIDTH+1)'(1) << BIT_POS;

   logic                  valid_ff;
   logic [RAD_WIDTH-1:0]  rad_ff, rad_in;
   logic [RAD_WIDTH:0]    res_ff, res_in;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [RAD_WIDTH:0]    trial;

   // trial subtract of res + bit
   always_comb begin
      trial = res_i + BIT_VAL;
      if ({1'b0, rad_i} >= trial) begin
         rad_in = rad_i - trial[RAD_WIDTH-1:0];
         res_in = (res_i >> 1) + BIT_VAL;
      end else begin
         rad_in = rad_i;
         res_in = res_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         res_ff  <= res_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign rad_o   = rad_ff;
   assign res_o   = res_ff;
   assign side_o  = side_ff;
endmodule
`default_nettype wire

[src/mgps_cordic_cell.sv]
// One rotation-mode CORDIC cell: a fixed shift and arctangent step.
// Uses mgps_pkg for the angle width and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module mgps_cordic_cell #(
   parameter int XY_WIDTH   = 35,
   parameter int SHIFT      = 0,
   parameter int SIDE_WIDTH = 17
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        en,
   input  wire                                        valid_i,
   input  wire  signed [XY_WIDTH-1:0]                 x_i,
   input  wire  signed [XY_WIDTH-1:0]                 y_i,
   input  wire  signed [mgps_pkg::ANGLE_WIDTH-1:0]    z_i,
   input  wire         [SIDE_WIDTH-1:0]               side_i,
   output logic                                       valid_o,
   output logic signed [XY_WIDTH-1:0]                 x_o,
   output logic signed [XY_WIDTH-1:0]                 y_o,
   output logic signed [mgps_pkg::ANGLE_WIDTH-1:0]    z_o,
   output logic        [SIDE_WIDTH-1:0]               side_o
);
   localparam logic signed [mgps_pkg::ANGLE_WIDTH-1:0] ATAN = mgps_pkg::ATAN_STEPS[SHIFT];

   logic                                    valid_ff;
   logic signed [XY_WIDTH-1:0]              x_ff, x_in, y_ff, y_in;
   logic signed [mgps_pkg::ANGLE_WIDTH-1:0] z_ff, z_in;
   logic        [SIDE_WIDTH-1:0]            side_ff;
   logic signed [XY_WIDTH-1:0]              dx, dy;

   // rotate toward zero residual angle
   always_comb begin
      dx = y_i >>> SHIFT;
      dy = x_i >>> SHIFT;
      if (!z_i[mgps_pkg::ANGLE_WIDTH-1]) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign side_o  = side_ff;
endmodule
`default_nettype wire
